FILE: rtl/core/gpca_pkg.sv
// Shared types and constants for the phase/code alignment block.
package gpca_pkg;

  localparam int MEAS_W       = 48;
  localparam int ARC_W        = 16;
  localparam int SAT_W        = 6;
  localparam int WL_W         = 20;
  localparam int NUM_SATS_DEF = 64;
  localparam int CFG_IDX_W    = 1;

  // 0.107 m in 2^-16 m units, truncated
  localparam logic [WL_W-1:0] WL_DEFAULT = WL_W'(7012);

  localparam logic [MEAS_W-1:0] MEAS_MAX = {1'b0, {(MEAS_W-1){1'b1}}};
  localparam logic [MEAS_W-1:0] MEAS_MIN = {1'b1, {(MEAS_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_ARCS   = 1'b0,
    REG_WAVELENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAT_W-1:0]         sat_index;
    logic                     flag_present;
    logic                     slip_flag;
    logic                     arc_present;
    logic [ARC_W-1:0]         arc_number;
    logic signed [MEAS_W-1:0] code_value;
    logic signed [MEAS_W-1:0] phase_value;
  } in_item_t;

  typedef struct packed {
    logic [SAT_W-1:0]         out_sat_index;
    logic signed [MEAS_W-1:0] aligned_phase;
    logic                     rejected;
  } out_item_t;

  // one slot of per-satellite state
  typedef struct packed {
    logic [ARC_W-1:0]  arc;
    logic [MEAS_W-1:0] offset;
  } tbl_entry_t;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [MEAS_W-1:0] dividend;
    logic [WL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [WL_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/core/gpca_div.sv
// Bit-serial restoring divider, remainder only, one dividend bit per cycle.
module gpca_div
  import gpca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(MEAS_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MEAS_W-1:0] dvd_r;
  logic [WL_W-1:0]   dsr_r;
  logic [WL_W-1:0]   rem_r;
  logic [WL_W:0]     trial;
  logic [WL_W:0]     trial_sub;

  assign trial     = {rem_r, dvd_r[MEAS_W-1]};
  assign trial_sub = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MEAS_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[MEAS_W-2:0], 1'b0};
      // remainder stays below divisor, so the low bits hold it
      rem_r <= trial_sub[WL_W] ? trial[WL_W-1:0] : trial_sub[WL_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: rtl/core/gpca_table.sv
// Per-satellite arc/offset store with valid bits so reset reads as zero.
module gpca_table
  import gpca_pkg::*;
#(
  parameter int NUM_SATS = NUM_SATS_DEF,
  parameter int IDX_W    = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output tbl_entry_t       rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  tbl_entry_t       wr_data
);

  tbl_entry_t          mem [NUM_SATS];
  logic [NUM_SATS-1:0] vld_r;
  tbl_entry_t          rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: rtl/core/gnss_phase_code_alignment.sv
// Top level: carrier-phase to code alignment with per-satellite offset tracking.
//
// Each request carries one satellite's code and carrier phase (signed, 2^-16 m
// units). The block keeps a stored arc number and phase offset per satellite
// slot, both zero after reset. A restart (slip flag set when use_arcs is 0, or
// an arc number above the stored one when use_arcs is 1) recomputes the offset
// as floor((code - phase) / wavelength) * wavelength, saturated; the result is
// phase plus the slot's offset, saturated. A request whose needed indicator is
// missing, or whose slot is at or above NUM_SATS, returns rejected = 1 with a
// zero phase and leaves the state alone. The remainder of the division comes
// from a single bit-serial divider, so a request with a restart passes through
// ST_CHECK, ST_DIV, ST_FIX and ST_SUM, and one without a restart through
// ST_CHECK and ST_SUM; in_ready is high only while the sequencer is idle. The
// result sits in an output register, so the next request is taken while it
// waits for out_ready. Writing a wavelength of zero loads the 0.107 m default.
// Configuration must be written only while the block is idle; the block does not enforce it.
module gnss_phase_code_alignment
  import gpca_pkg::*;
#(
  parameter int NUM_SATS = NUM_SATS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WL_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;

  // limits on the unsigned offset magnitude before negation
  localparam logic [MEAS_W:0] OM_POS_LIM = {2'b00, {(MEAS_W-1){1'b1}}};
  localparam logic [MEAS_W:0] OM_NEG_LIM = {2'b01, {(MEAS_W-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_FIX   = 5'b01000,
    ST_SUM   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic            use_arcs_r;
  logic [WL_W-1:0] wl_r;

  // request being worked on
  in_item_t          item_r;
  logic              rej_r;
  logic              neg_r;
  logic [MEAS_W-1:0] mag_r;
  logic [MEAS_W-1:0] off_r;

  out_item_t out_data_r;
  logic      out_valid_r;

  // table and divider hookup
  logic [SAT_W+IDX_W-1:0] in_sat_ext;
  logic [SAT_W+IDX_W-1:0] item_sat_ext;
  tbl_entry_t             tbl_rd;
  tbl_entry_t             tbl_wr;
  logic                   tbl_rd_en;
  logic                   tbl_wr_en;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // check stage
  logic            sat_ok;
  logic            present;
  logic            restart;
  logic            reject;
  logic [MEAS_W:0] diff;
  logic [MEAS_W:0] diff_neg;
  logic [MEAS_W:0] mag_full;

  // offset fix-up stage
  logic              adj;
  logic [MEAS_W:0]   om_base;
  logic [MEAS_W:0]   om;
  logic [MEAS_W:0]   om_neg;
  logic [MEAS_W-1:0] off_new;

  // output sum
  logic [MEAS_W:0]   sum;
  logic [MEAS_W-1:0] sum_sat;

  assign in_sat_ext   = {{IDX_W{1'b0}}, in_data.sat_index};
  assign item_sat_ext = {{IDX_W{1'b0}}, item_r.sat_index};

  assign in_ready  = (state_r == ST_IDLE);
  assign tbl_rd_en = in_valid && in_ready;

  gpca_table #(
    .NUM_SATS (NUM_SATS),
    .IDX_W    (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_addr (in_sat_ext[IDX_W-1:0]),
    .rd_data (tbl_rd),
    .wr_en   (tbl_wr_en),
    .wr_addr (item_sat_ext[IDX_W-1:0]),
    .wr_data (tbl_wr)
  );

  gpca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // restart and reject decision and code-phase magnitude; table data is valid in ST_CHECK and held after
  always_comb begin
    sat_ok   = (int'(item_r.sat_index) < NUM_SATS);
    present  = use_arcs_r ? item_r.arc_present : item_r.flag_present;
    reject   = !sat_ok || !present;
    restart  = use_arcs_r ? (tbl_rd.arc < item_r.arc_number) : item_r.slip_flag;
    diff     = {item_r.code_value[MEAS_W-1], item_r.code_value}
             - {item_r.phase_value[MEAS_W-1], item_r.phase_value};
    diff_neg = ~diff + 1'b1;
    mag_full = diff[MEAS_W] ? diff_neg : diff;
  end

  assign div_req.start    = (state_r == ST_CHECK) && !reject && restart;
  assign div_req.dividend = mag_full[MEAS_W-1:0];
  assign div_req.divisor  = wl_r;

  // q * wl is mag - rem; negative side rounds away from zero
  always_comb begin
    adj     = neg_r && (div_rsp.rem != '0);
    om_base = {1'b0, mag_r} - {{(MEAS_W+1-WL_W){1'b0}}, div_rsp.rem};
    om      = om_base + (adj ? {{(MEAS_W+1-WL_W){1'b0}}, wl_r} : '0);
    om_neg  = ~om + 1'b1;
    if (!neg_r) begin
      off_new = (om > OM_POS_LIM) ? MEAS_MAX : om[MEAS_W-1:0];
    end else begin
      off_new = (om > OM_NEG_LIM) ? MEAS_MIN : om_neg[MEAS_W-1:0];
    end
  end

  assign tbl_wr_en     = (state_r == ST_FIX);
  assign tbl_wr.offset = off_new;
  assign tbl_wr.arc    = use_arcs_r ? item_r.arc_number : tbl_rd.arc;

  // saturating phase + offset
  always_comb begin
    sum = {item_r.phase_value[MEAS_W-1], item_r.phase_value} + {off_r[MEAS_W-1], off_r};
    if (sum[MEAS_W] != sum[MEAS_W-1]) begin
      sum_sat = sum[MEAS_W] ? MEAS_MIN : MEAS_MAX;
    end else begin
      sum_sat = sum[MEAS_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = div_req.start ? ST_DIV : ST_SUM;
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_FIX;
      end
      ST_FIX: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_arcs_r <= 1'b0;
      wl_r       <= WL_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USE_ARCS:   use_arcs_r <= cfg_wdata[0];
        REG_WAVELENGTH: wl_r <= (cfg_wdata == '0) ? WL_DEFAULT : cfg_wdata;
        default: ;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (tbl_rd_en) begin
      item_r <= in_data;
    end
    if (state_r == ST_CHECK) begin
      rej_r <= reject;
      neg_r <= diff[MEAS_W];
      mag_r <= mag_full[MEAS_W-1:0];
      off_r <= tbl_rd.offset;
    end
    if (state_r == ST_FIX) begin
      off_r <= off_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_SUM) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_SUM) && (!out_valid_r || out_ready)) begin
      out_data_r.out_sat_index <= item_r.sat_index;
      out_data_r.aligned_phase <= rej_r ? '0 : sum_sat;
      out_data_r.rejected      <= rej_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
